@@ rtl/icp_pkg.sv @@
// ----------------------------------------------------------------------------
// icp_pkg: IR compressed code player shared definitions
// Constants, request and config register codes and the result item type.
// ----------------------------------------------------------------------------
package icp_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int TAB_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ITEM_CAP    = 600;
  localparam int ITEM_W      = $clog2(ITEM_CAP) + 1;

  localparam int DUR_W   = 15;
  localparam int MARK_W  = 13;
  localparam int SPACE_W = 14;
  localparam int US_W    = 18;  // space x10 up to 160000 us

  localparam logic [DUR_W-1:0]   MAX_DUR   = DUR_W'(32000);
  localparam logic [SPACE_W-1:0] SPACE_SAT = SPACE_W'(16000);
  localparam logic [ITEM_W-1:0]  ITEM_STOP = ITEM_W'(ITEM_CAP - 8);

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_START = 2'd1,
    REQ_BYTE  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [0:0] {
    CFG_INDEX_BITS = 1'b0,
    CFG_PAIR_COUNT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic             first_level;
    logic [DUR_W-1:0] first_duration;
    logic             second_level;
    logic [DUR_W-1:0] second_duration;
    logic             last_item;
  } item_t;

endpackage

@@ rtl/icp_if.sv @@
// ----------------------------------------------------------------------------
// icp_req_if / icp_item_if: request and result channels
// Valid/ready channels; a transfer happens when both are high.
// ----------------------------------------------------------------------------
interface icp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [3:0]  entry_index;
  logic [12:0] mark_tens;
  logic [13:0] space_tens;
  logic [7:0]  code_byte;

  modport source (output valid, req_type, entry_index, mark_tens, space_tens, code_byte,
                  input ready);
  modport sink   (input valid, req_type, entry_index, mark_tens, space_tens, code_byte,
                  output ready);
endinterface

interface icp_item_if;
  logic        valid;
  logic        ready;
  logic        first_level;
  logic [14:0] first_duration;
  logic        second_level;
  logic [14:0] second_duration;
  logic        last_item;

  modport source (output valid, first_level, first_duration, second_level,
                  second_duration, last_item, input ready);
  modport sink   (input valid, first_level, first_duration, second_level,
                  second_duration, last_item, output ready);
endinterface

@@ rtl/ir_compressed_code_player_unit.sv @@
// ----------------------------------------------------------------------------
// ir_compressed_code_player_unit: compressed IR code player
// Loads a mark/space timing table, unpacks code bytes into table indices and
// plays each index as a pulse item plus all-low filler items.
// ----------------------------------------------------------------------------
// Ordering: a byte's first item passes UNPACK, LOAD, PAIR and the output register;
//   load and start requests take effect at their transfer, back to back.
// Throughput: one item per cycle while the sink is ready, with UNPACK and LOAD
//   between indices; no new request is taken until a byte's indices are played.
// Reset (sync, rst_n low): idle, no item pending, buffer and counters zero,
//   code finished, index_bits 2, pair_count 0; timing table not cleared.
module ir_compressed_code_player_unit (
  input  logic       clk,
  input  logic       rst_n,
  icp_req_if.sink    in_ch,
  icp_item_if.source out_ch,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data
);

  // one-hot sequencer states
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_UNPACK = 5'b00010,  // pull next index out of the bit buffer
    S_LOAD   = 5'b00100,  // table read, x10, clamp
    S_PAIR   = 5'b01000,  // emit pulse item
    S_FILL   = 5'b10000   // emit filler items
  } state_t;

  state_t state_r, state_nxt;

  // config
  logic [2:0] index_bits_r;
  logic [7:0] pair_count_r;

  // timing table: mark and space per entry
  logic [icp_pkg::MARK_W-1:0]  tab_mark_r  [icp_pkg::TABLE_DEPTH];
  logic [icp_pkg::SPACE_W-1:0] tab_space_r [icp_pkg::TABLE_DEPTH];

  // unpack state
  logic [11:0] buf_r, buf_nxt;
  logic [3:0]  bits_r, bits_nxt;
  logic [2:0]  width_r, width_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [7:0]  pairs_done_r, pairs_done_nxt;
  logic [icp_pkg::ITEM_W-1:0] items_r, items_nxt;
  logic        finished_r, finished_nxt;

  // current pair
  logic [icp_pkg::DUR_W-1:0] mark_r, mark_nxt;
  logic [icp_pkg::DUR_W-1:0] first_r, first_nxt;
  logic [icp_pkg::US_W-1:0]  left_r, left_nxt;

  // output register
  icp_pkg::item_t out_r, out_nxt;
  logic           out_valid_r, out_valid_nxt;

  // datapath temporaries
  logic                        in_xfer;
  logic                        out_free;
  logic [2:0]                  width_clamp;
  logic [3:0]                  shamt;
  logic [11:0]                 shifted;
  logic [4:0]                  idx_mask;
  logic                        idx_hit;
  logic [icp_pkg::TAB_AW-1:0]  rd_addr;
  logic [icp_pkg::MARK_W-1:0]  rd_mark;
  logic [icp_pkg::SPACE_W-1:0] rd_space;
  logic [16:0]                 mark_us;
  logic [icp_pkg::US_W-1:0]    space_scaled;
  logic [icp_pkg::US_W-1:0]    chunk;
  logic [icp_pkg::DUR_W-1:0]   half;
  logic                        pair_last;
  logic                        code_end;
  logic [icp_pkg::SPACE_W-1:0] load_space;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.first_level     = out_r.first_level;
  assign out_ch.first_duration  = out_r.first_duration;
  assign out_ch.second_level    = out_r.second_level;
  assign out_ch.second_duration = out_r.second_duration;
  assign out_ch.last_item       = out_r.last_item;

  // index width: 0 acts as 1, above 4 acts as 4
  always_comb begin
    if (index_bits_r == 3'd0) begin
      width_clamp = 3'd1;
    end else if (index_bits_r > 3'd4) begin
      width_clamp = 3'd4;
    end else begin
      width_clamp = index_bits_r;
    end
  end

  // index extraction from the top of the buffered bits
  assign shamt    = bits_r - {1'b0, width_r};
  assign shifted  = buf_r >> shamt;
  assign idx_mask = (5'd1 << width_r) - 5'd1;

  // table read and x10 scaling (shift-add)
  assign idx_hit      = ({1'b0, idx_r} < 5'(icp_pkg::TABLE_DEPTH));
  assign rd_addr      = idx_r[icp_pkg::TAB_AW-1:0];
  assign rd_mark      = idx_hit ? tab_mark_r[rd_addr]  : '0;
  assign rd_space     = idx_hit ? tab_space_r[rd_addr] : '0;
  assign mark_us      = ({4'd0, rd_mark} << 3) + ({4'd0, rd_mark} << 1);
  assign space_scaled = ({4'd0, rd_space} << 3) + ({4'd0, rd_space} << 1);

  // filler chunk: at most MAX_DUR, split floor half first
  assign chunk = (left_r > icp_pkg::US_W'(icp_pkg::MAX_DUR)) ?
                 icp_pkg::US_W'(icp_pkg::MAX_DUR) : left_r;
  assign half  = icp_pkg::DUR_W'(chunk >> 1);

  // code ends on this pair's final item
  assign code_end = ({1'b0, pairs_done_r} + 9'd1 >= {1'b0, pair_count_r}) ||
                    (items_r + icp_pkg::ITEM_W'(1) > icp_pkg::ITEM_STOP);

  assign load_space = (in_ch.space_tens > icp_pkg::SPACE_SAT) ?
                      icp_pkg::SPACE_SAT : in_ch.space_tens;

  always_comb begin
    state_nxt      = state_r;
    buf_nxt        = buf_r;
    bits_nxt       = bits_r;
    width_nxt      = width_r;
    idx_nxt        = idx_r;
    pairs_done_nxt = pairs_done_r;
    items_nxt      = items_r;
    finished_nxt   = finished_r;
    mark_nxt       = mark_r;
    first_nxt      = first_r;
    left_nxt       = left_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    pair_last      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (icp_pkg::req_t'(in_ch.req_type))
            icp_pkg::REQ_START: begin
              buf_nxt        = '0;
              bits_nxt       = '0;
              pairs_done_nxt = '0;
              items_nxt      = '0;
              finished_nxt   = (pair_count_r == 8'd0);
            end
            icp_pkg::REQ_BYTE: begin
              if (!finished_r) begin
                buf_nxt   = {buf_r[3:0], in_ch.code_byte};
                bits_nxt  = bits_r + 4'd8;
                width_nxt = width_clamp;
                state_nxt = S_UNPACK;
              end
            end
            default: ;  // loads go to the table below; unknown does nothing
          endcase
        end
      end
      S_UNPACK: begin
        if (!finished_r && bits_r >= {1'b0, width_r}) begin
          idx_nxt   = shifted[3:0] & idx_mask[3:0];
          bits_nxt  = shamt;
          state_nxt = S_LOAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_LOAD: begin
        mark_nxt  = (mark_us > 17'(icp_pkg::MAX_DUR)) ? icp_pkg::MAX_DUR :
                    icp_pkg::DUR_W'(mark_us);
        if (space_scaled > icp_pkg::US_W'(icp_pkg::MAX_DUR)) begin
          first_nxt = icp_pkg::MAX_DUR;
          left_nxt  = space_scaled - icp_pkg::US_W'(icp_pkg::MAX_DUR);
        end else begin
          first_nxt = icp_pkg::DUR_W'(space_scaled);
          left_nxt  = '0;
        end
        state_nxt = S_PAIR;
      end
      S_PAIR: begin
        if (out_free) begin
          pair_last                 = (left_r == '0);
          out_valid_nxt             = 1'b1;
          out_nxt.first_level       = 1'b1;
          out_nxt.first_duration    = mark_r;
          out_nxt.second_level      = 1'b0;
          out_nxt.second_duration   = first_r;
          out_nxt.last_item         = pair_last && code_end;
          items_nxt                 = items_r + icp_pkg::ITEM_W'(1);
          state_nxt                 = pair_last ? S_UNPACK : S_FILL;
        end
      end
      S_FILL: begin
        if (out_free) begin
          pair_last                 = (left_r <= icp_pkg::US_W'(icp_pkg::MAX_DUR));
          out_valid_nxt             = 1'b1;
          out_nxt.first_level       = 1'b0;
          out_nxt.first_duration    = half;
          out_nxt.second_level      = 1'b0;
          out_nxt.second_duration   = icp_pkg::DUR_W'(chunk) - half;
          out_nxt.last_item         = pair_last && code_end;
          items_nxt                 = items_r + icp_pkg::ITEM_W'(1);
          left_nxt                  = left_r - chunk;
          state_nxt                 = pair_last ? S_UNPACK : S_FILL;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // end of a pair: count it, close the code if done
    if (pair_last) begin
      pairs_done_nxt = pairs_done_r + 8'd1;
      if (code_end) begin
        finished_nxt = 1'b1;
        buf_nxt      = '0;
        bits_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      buf_r        <= '0;
      bits_r       <= '0;
      pairs_done_r <= '0;
      items_r      <= '0;
      finished_r   <= 1'b1;
      out_valid_r  <= 1'b0;
      index_bits_r <= 3'd2;
      pair_count_r <= 8'd0;
    end else begin
      state_r      <= state_nxt;
      buf_r        <= buf_nxt;
      bits_r       <= bits_nxt;
      pairs_done_r <= pairs_done_nxt;
      items_r      <= items_nxt;
      finished_r   <= finished_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (icp_pkg::cfg_reg_t'(cfg_index))
          icp_pkg::CFG_INDEX_BITS: index_bits_r <= cfg_data[2:0];
          icp_pkg::CFG_PAIR_COUNT: pair_count_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    width_r <= width_nxt;
    idx_r   <= idx_nxt;
    mark_r  <= mark_nxt;
    first_r <= first_nxt;
    left_r  <= left_nxt;
    out_r   <= out_nxt;
  end

  // timing table write; space saturates on load
  always_ff @(posedge clk) begin
    if (in_xfer && in_ch.req_type == icp_pkg::REQ_LOAD &&
        {1'b0, in_ch.entry_index} < 5'(icp_pkg::TABLE_DEPTH)) begin
      tab_mark_r[in_ch.entry_index[icp_pkg::TAB_AW-1:0]]  <= in_ch.mark_tens;
      tab_space_r[in_ch.entry_index[icp_pkg::TAB_AW-1:0]] <= load_space;
    end
  end

  // ---------------------------------------------------------------- checks
  a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FILL |-> left_r != '0)
    else $error("filler state with no space left");

  a_finished_empty: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> bits_r == 4'd0)
    else $error("bits buffered after code end");

  a_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bits_r <= 4'd11)
    else $error("bit buffer overfilled");

  a_filler_dur: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.first_level |->
      ({1'b0, out_r.first_duration} + {1'b0, out_r.second_duration} <=
       {1'b0, icp_pkg::MAX_DUR}) && out_r.first_duration <= out_r.second_duration)
    else $error("filler item split wrong");

  a_pair_advance: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOAD |=> state_r == S_PAIR)
    else $error("table read not followed by pulse item");

endmodule

@@ dv/icp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icp_checker: item predictor and scoreboard for the IR code player
// Keeps its own timing table, bit buffer and counters from the observed
// request, config and item transfers, and compares every item in order.
// ----------------------------------------------------------------------------
module icp_checker
  import icp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  icp_req_if         req_mon,
  icp_item_if        item_mon,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         fail_count,
  output int         items_open
);

  logic [MARK_W-1:0]  mark_tab  [TABLE_DEPTH];
  logic [SPACE_W-1:0] space_tab [TABLE_DEPTH];
  int unsigned        bit_buf;
  int unsigned        buf_bits;
  int unsigned        pairs_played;
  int unsigned        items_played;
  bit                 code_done;
  logic [2:0]         width_reg;
  logic [7:0]         pair_total;
  item_t              due_items [$];
  item_t              got_item;
  item_t              want_item;

  initial begin
    fail_count = 0;
    items_open = 0;
    foreach (mark_tab[i]) begin
      mark_tab[i]  = '0;
      space_tab[i] = '0;
    end
  end

  function automatic string describe(item_t it);
    return $sformatf("lvl %0d/%0d dur %0d/%0d last %0d", it.first_level,
                     it.second_level, it.first_duration, it.second_duration,
                     it.last_item);
  endfunction

  // pulse item for one table index, then the filler items of its long space
  function automatic void play_index(int unsigned idx);
    int unsigned mark_us;
    int unsigned space_total;
    int unsigned head_us;
    int unsigned left_us;
    int unsigned chunk_us;
    item_t       it;
    mark_us     = 0;
    space_total = 0;
    if (idx < TABLE_DEPTH) begin
      mark_us     = int'(mark_tab[idx]) * 10;
      space_total = int'(space_tab[idx]) * 10;
    end
    if (mark_us > MAX_DUR) mark_us = MAX_DUR;
    head_us = (space_total > MAX_DUR) ? MAX_DUR : space_total;
    it = '0;
    it.first_level     = 1'b1;
    it.first_duration  = DUR_W'(mark_us);
    it.second_duration = DUR_W'(head_us);
    due_items.push_back(it);
    items_played++;
    left_us = space_total - head_us;
    while (left_us > 0) begin
      chunk_us = (left_us > MAX_DUR) ? MAX_DUR : left_us;
      it = '0;
      it.first_duration  = DUR_W'(chunk_us / 2);
      it.second_duration = DUR_W'(chunk_us - chunk_us / 2);
      due_items.push_back(it);
      items_played++;
      left_us -= chunk_us;
    end
  endfunction

  // MSB-first unpack; indices may straddle byte boundaries
  function automatic void unpack_code_byte(logic [7:0] code);
    int unsigned width;
    int unsigned idx;
    item_t       tail;
    width    = (width_reg == 3'd0) ? 1 : (width_reg > 3'd4) ? 4 : width_reg;
    bit_buf  = ((bit_buf << 8) | code) & 'hFFF;
    buf_bits += 8;
    while (buf_bits >= width && !code_done) begin
      idx = (bit_buf >> (buf_bits - width)) & ((1 << width) - 1);
      buf_bits -= width;
      play_index(idx);
      pairs_played++;
      if (pairs_played >= pair_total || items_played > ITEM_CAP - 8) begin
        tail = due_items.pop_back();
        tail.last_item = 1'b1;
        due_items.push_back(tail);
        code_done = 1'b1;
        bit_buf   = 0;
        buf_bits  = 0;
      end
    end
    bit_buf &= (1 << buf_bits) - 1;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      bit_buf      = 0;
      buf_bits     = 0;
      pairs_played = 0;
      items_played = 0;
      code_done    = 1'b1;
      width_reg    = 3'd2;
      pair_total   = 8'd0;
      due_items.delete();
    end else begin
      // items first, so one arriving on an empty queue is never masked
      if (item_mon.valid && item_mon.ready) begin
        got_item = {item_mon.first_level, item_mon.first_duration, item_mon.second_level,
                    item_mon.second_duration, item_mon.last_item};
        if (due_items.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("checker: item with nothing expected, got %s", describe(got_item));
        end else begin
          want_item = due_items.pop_front();
          if (got_item !== want_item) begin
            fail_count++;
            if (fail_count <= 10)
              $display("checker: item mismatch, expected %s, got %s",
                       describe(want_item), describe(got_item));
          end
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_INDEX_BITS: width_reg  = cfg_data[2:0];
          CFG_PAIR_COUNT: pair_total = cfg_data;
          default: ;
        endcase
      end
      if (req_mon.valid && req_mon.ready) begin
        case (req_t'(req_mon.req_type))
          REQ_LOAD: begin
            if (req_mon.entry_index < TABLE_DEPTH) begin
              mark_tab[req_mon.entry_index]  = req_mon.mark_tens;
              space_tab[req_mon.entry_index] = (req_mon.space_tens > SPACE_SAT) ?
                                               SPACE_SAT : req_mon.space_tens;
            end
          end
          REQ_START: begin
            bit_buf      = 0;
            buf_bits     = 0;
            pairs_played = 0;
            items_played = 0;
            code_done    = (pair_total == 8'd0);
          end
          REQ_BYTE: begin
            if (!code_done) unpack_code_byte(req_mon.code_byte);
          end
          default: ;
        endcase
      end
    end
    items_open = due_items.size();
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for ir_compressed_code_player_unit
// Loads timing tables, plays directed and random codes over three idle
// profiles and a long output stall; icp_checker predicts and compares items.
// ----------------------------------------------------------------------------
module tb_top;
  import icp_pkg::*;

  // After the last item is out we give the block this much time before
  // touching config or ending the run.
  localparam int TAIL_CYCLES = 64;
  // Long output stall used to back the block up into its request channel.
  localparam int HOLD_CYCLES = 300;
  // Cap on the whole run, set well above the slowest correct run.
  localparam int CYCLE_LIMIT = 1_000_000;

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [0:0] cfg_index = CFG_INDEX_BITS;
  logic [7:0] cfg_data  = 8'd0;

  int         fail_count;
  int         items_open;
  int         tx_idle_pct  = 0;
  int         rx_idle_pct  = 0;
  int         useful_items = 0;
  int         hold_reqs    = 0;
  int         cycle_count  = 0;

  // shadow of what the block was last configured with, to size codes
  logic [2:0] cur_index_bits = 3'd2;
  logic [7:0] cur_pair_count = 8'd0;

  icp_req_if  in_ch ();
  icp_item_if out_ch ();

  ir_compressed_code_player_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  icp_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_mon    (in_ch),
    .item_mon   (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .items_open (items_open)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard stop: anything still hanging here is a hang or a lost item.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Item sink. Random ready per the current idle profile; a bump of
  // hold_reqs makes it hold ready low, counting HOLD_CYCLES down here.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left    = 0;
    hold_seen    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_seen != hold_reqs) begin
        hold_seen    = hold_reqs;
        hold_left    = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // One request transfer. Fields the request kind does not use carry junk,
  // so every payload bit toggles; the block must ignore them.
  task automatic send_req(input req_t kind, input logic [3:0] entry,
                          input logic [12:0] mark, input logic [13:0] space,
                          input logic [7:0] code, input bit counted);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= kind;
    in_ch.entry_index <= (kind == REQ_LOAD) ? entry : 4'($urandom);
    in_ch.mark_tens   <= (kind == REQ_LOAD) ? mark  : 13'($urandom);
    in_ch.space_tens  <= (kind == REQ_LOAD) ? space : 14'($urandom);
    in_ch.code_byte   <= (kind == REQ_BYTE) ? code  : 8'($urandom);
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (counted) useful_items++;
  endtask

  // Stop sending, let every predicted item drain, then give the block its
  // tail time. Pending count is read at negedge to stay clear of the edge.
  task automatic drain_idle();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (items_open != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Only called with the block idle; writes both registers.
  task automatic set_config(input logic [7:0] width_word, input logic [7:0] pairs);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_INDEX_BITS;
    cfg_data  <= width_word;
    @(posedge clk);
    cfg_index <= CFG_PAIR_COUNT;
    cfg_data  <= pairs;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_index_bits = width_word[2:0];
    cur_pair_count = pairs;
  endtask

  // bytes needed to carry every index of a full code at the current width
  function automatic int code_bytes();
    int width;
    width = (cur_index_bits == 3'd0) ? 1 : (cur_index_bits > 3'd4) ? 4 : cur_index_bits;
    return (cur_pair_count * width + 7) / 8;
  endfunction

  // Spaces lean short so items stay cheap, with saturation, the saturation
  // limit and the just-over-one-chunk boundary mixed in.
  function automatic logic [13:0] pick_space();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return 14'($urandom_range(3200));
      5, 6, 7:       return 14'($urandom);
      8:             return 14'd16000;
      default:       return 14'd3201;
    endcase
  endfunction

  // Mostly complete codes with random bytes; some reconfig, table reloads,
  // unknown requests, codes cut short by a new start and stray bytes.
  task automatic random_traffic(input int tx_pct, input int rx_pct, input int quota);
    int         goal;
    int         roll;
    logic [7:0] width_word;
    logic [7:0] pairs;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    goal        = useful_items + quota;
    while (useful_items < goal) begin
      roll = $urandom_range(99);
      if (roll < 15) begin
        drain_idle();
        width_word      = 8'($urandom);
        width_word[2:0] = ($urandom_range(3) == 0) ? 3'($urandom) : 3'($urandom_range(4, 1));
        roll  = $urandom_range(39);
        pairs = (roll == 0) ? 8'd0 : (roll == 1) ? 8'd255 :
                (roll < 6) ? 8'd1 : 8'($urandom_range(24, 2));
        set_config(width_word, pairs);
      end else if (roll < 30) begin
        repeat ($urandom_range(3, 1))
          send_req(REQ_LOAD, 4'($urandom), 13'($urandom), pick_space(), 8'd0, 1'b1);
      end else if (roll < 33) begin
        send_req(REQ_NONE, 4'd0, 13'd0, 14'd0, 8'd0, 1'b0);
      end else if (roll < 38) begin
        // partial code; whatever comes next abandons or continues it
        send_req(REQ_START, 4'd0, 13'd0, 14'd0, 8'd0, 1'b1);
        repeat ($urandom_range(code_bytes() / 2))
          send_req(REQ_BYTE, 4'd0, 13'd0, 14'd0, 8'($urandom), 1'b1);
      end else begin
        send_req(REQ_START, 4'd0, 13'd0, 14'd0, 8'd0, 1'b1);
        repeat (code_bytes())
          send_req(REQ_BYTE, 4'd0, 13'd0, 14'd0, 8'($urandom), 1'b1);
        // byte after the code is over: dropped by the block
        if ($urandom_range(3) == 0)
          send_req(REQ_BYTE, 4'd0, 13'd0, 14'd0, 8'($urandom), 1'b0);
      end
    end
    drain_idle();
  endtask

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.req_type    = REQ_NONE;
    in_ch.entry_index = '0;
    in_ch.mark_tens   = '0;
    in_ch.space_tens  = '0;
    in_ch.code_byte   = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // -- directed ------------------------------------------------------------
    // Whole table gets written up front: no code may ever read an entry
    // that was never loaded, and 4-bit indices reach all sixteen.
    send_req(REQ_LOAD, 4'd0, 13'd0,    14'd0,     8'd0, 1'b1); // zero mark, zero space
    send_req(REQ_LOAD, 4'd1, 13'd8191, 14'd16383, 8'd0, 1'b1); // clamp mark, saturate space
    send_req(REQ_LOAD, 4'd2, 13'd3200, 14'd3200,  8'd0, 1'b1); // exactly one chunk each
    send_req(REQ_LOAD, 4'd3, 13'd3201, 14'd3201,  8'd0, 1'b1); // just over: 10 us filler
    send_req(REQ_LOAD, 4'd4, 13'd1,    14'd6401,  8'd0, 1'b1); // full chunk plus a sliver
    send_req(REQ_LOAD, 4'd5, 13'd6553, 14'd16000, 8'd0, 1'b1); // clamped mark, saturation-limit space
    send_req(REQ_LOAD, 4'd6, 13'd4096, 14'd8191,  8'd0, 1'b1);
    send_req(REQ_LOAD, 4'd7, 13'd10,   14'd1,     8'd0, 1'b1);
    for (int e = 8; e < 16; e++)
      send_req(REQ_LOAD, 4'(e), 13'($urandom), pick_space(), 8'd0, 1'b1);

    send_req(REQ_NONE,  4'd0, 13'd0, 14'd0, 8'd0,  1'b1); // unknown request
    send_req(REQ_BYTE,  4'd0, 13'd0, 14'd0, 8'hA5, 1'b1); // no code running yet
    send_req(REQ_START, 4'd0, 13'd0, 14'd0, 8'd0,  1'b1); // pair_count 0: done at once

    // 4-bit indices (upper data bits set and ignored), three pairs
    drain_idle();
    set_config(8'hFC, 8'd3);
    send_req(REQ_START, 4'd0, 13'd0, 14'd0, 8'd0,  1'b1);
    send_req(REQ_BYTE,  4'd0, 13'd0, 14'd0, 8'h01, 1'b1); // entries 0, 1
    send_req(REQ_BYTE,  4'd0, 13'd0, 14'd0, 8'h2F, 1'b1); // entry 2 ends it, 15 dropped
    // restart mid-code: two pairs played, then abandoned without a last item
    send_req(REQ_START, 4'd0, 13'd0, 14'd0, 8'd0,  1'b1);
    send_req(REQ_BYTE,  4'd0, 13'd0, 14'd0, 8'h34, 1'b1);
    send_req(REQ_START, 4'd0, 13'd0, 14'd0, 8'd0,  1'b1);
    send_req(REQ_BYTE,  4'd0, 13'd0, 14'd0, 8'h7F, 1'b1); // entries 7, 15
    send_req(REQ_BYTE,  4'd0, 13'd0, 14'd0, 8'hE0, 1'b1); // entry 14, last

    // width 0 behaves as 1; single-pair code on entry 1 (five items)
    drain_idle();
    set_config(8'h00, 8'd1);
    send_req(REQ_START, 4'd0, 13'd0, 14'd0, 8'd0,  1'b1);
    send_req(REQ_BYTE,  4'd0, 13'd0, 14'd0, 8'h80, 1'b1);
    drain_idle();

    // -- random, three idle profiles ------------------------------------------
    random_traffic(26, 88, 140);
    random_traffic(88, 26, 140);

    // Backpressure plus item cap: entries 0 and 1 give five items per pair,
    // so at 1-bit indices and 255 pairs the code stops early on the cap.
    // The sink stalls for a long stretch while bytes keep coming.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_config(8'h01, 8'd255);
    send_req(REQ_LOAD, 4'd0, 13'($urandom), 14'd16000, 8'd0, 1'b1);
    send_req(REQ_LOAD, 4'd1, 13'($urandom), 14'd16000, 8'd0, 1'b1);
    hold_reqs++;
    send_req(REQ_START, 4'd0, 13'd0, 14'd0, 8'd0, 1'b1);
    repeat (16) send_req(REQ_BYTE, 4'd0, 13'd0, 14'd0, 8'($urandom), 1'b1);
    drain_idle();

    random_traffic(0, 0, 100);

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/icp_pkg.sv
rtl/icp_if.sv
rtl/ir_compressed_code_player_unit.sv
dv/icp_checker.sv
dv/tb_top.sv
